### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define LFRG_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define LFRG_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/lfrg_pkg.sv
// Package with the shared constants and types of the login failure rate gate.
`default_nettype none

package lfrg_pkg;

  // Number of stored failure timestamps.
  localparam int FAILURE_SLOTS_DEFAULT = 5;

  // Configuration register reset values.
  localparam logic [31:0] WINDOW_MS_RESET     = 32'd60000;
  localparam logic [2:0]  FAILURE_LIMIT_RESET = 3'd5;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GATE_ENABLED  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAILURE_LIMIT = 2'd2;

  // Decision codes.
  localparam logic [2:0] DEC_DISABLED     = 3'd0;
  localparam logic [2:0] DEC_RATE_LIMITED = 3'd1;
  localparam logic [2:0] DEC_CHALLENGE    = 3'd2;
  localparam logic [2:0] DEC_ALLOW        = 3'd3;
  localparam logic [2:0] DEC_FORBIDDEN    = 3'd4;

  // Update commands from the evaluation logic to the history registers.
  typedef struct packed {
    logic record;    // load compacted timestamps and count
    logic clear;     // drop history and cooldown
    logic set_cool;  // start a cooldown at the current time
  } hist_ctl_t;

endpackage

`default_nettype wire

### rtl/core/lfrg_eval.sv
// Single-pass evaluation of one request against the failure history.
`default_nettype none

module lfrg_eval #(
  parameter int FAILURE_SLOTS = lfrg_pkg::FAILURE_SLOTS_DEFAULT,
  localparam int CW = $clog2(FAILURE_SLOTS + 1)
) (
  input  wire logic                         active,
  input  wire logic                         gate_enabled,
  input  wire logic [31:0]                  window_ms,
  input  wire logic [2:0]                   failure_limit,
  input  wire logic [31:0]                  now_ms,
  input  wire logic                         is_authenticated,
  input  wire logic                         credential_given,
  input  wire logic                         is_mutation,
  input  wire logic                         mutation_checks_ok,
  input  wire logic [FAILURE_SLOTS-1:0][31:0] times,
  input  wire logic [CW-1:0]                count,
  input  wire logic                         cooling,
  input  wire logic [31:0]                  cooldown_start,
  output logic      [FAILURE_SLOTS-1:0][31:0] times_next,
  output logic      [CW-1:0]                count_next,
  output lfrg_pkg::hist_ctl_t               ctl,
  output logic      [2:0]                   decision
);

  localparam int EW = (CW > 3) ? CW : 3;

  logic [FAILURE_SLOTS-1:0]         keep;
  logic [FAILURE_SLOTS-1:0][CW-1:0] pos;
  logic [CW-1:0]                    kept;
  logic [EW-1:0]                    elim;
  logic                             append;
  logic                             set_cool;
  logic                             blocked_pre;
  logic [31:0]                      cool_age;

  // Effective limit: zero acts as one, anything above the slot count is clipped.
  always_comb begin
    elim = EW'(failure_limit);
    if (elim == '0) begin
      elim = EW'(1);
    end
    if (elim > EW'(FAILURE_SLOTS)) begin
      elim = EW'(FAILURE_SLOTS);
    end
  end

  // Cooldown check against the state left by the previous request.
  assign cool_age    = now_ms - cooldown_start;
  assign blocked_pre = cooling && (cool_age < window_ms);

  // Entries still inside the window, and their compacted positions.
  always_comb begin
    for (int i = 0; i < FAILURE_SLOTS; i++) begin
      keep[i] = (CW'(i) < count) && ((now_ms - times[i]) < window_ms);
    end
    for (int i = 0; i < FAILURE_SLOTS; i++) begin
      pos[i] = CW'($countones(keep & ~({FAILURE_SLOTS{1'b1}} << i)));
    end
    kept = CW'($countones(keep));
  end

  assign append     = EW'(kept) < elim;
  assign count_next = append ? kept + CW'(1) : kept;
  assign set_cool   = EW'(count_next) >= elim;

  // Move each kept entry down to its new slot and append the new failure.
  always_comb begin
    for (int j = 0; j < FAILURE_SLOTS; j++) begin
      times_next[j] = '0;
      for (int i = 0; i < FAILURE_SLOTS; i++) begin
        if (keep[i] && (pos[i] == CW'(j))) begin
          times_next[j] = times_next[j] | times[i];
        end
      end
      if (append && (kept == CW'(j))) begin
        times_next[j] = now_ms;
      end
    end
  end

  // Decision and history update commands.
  always_comb begin
    ctl      = '0;
    decision = lfrg_pkg::DEC_DISABLED;
    priority if (!gate_enabled) begin
      decision = lfrg_pkg::DEC_DISABLED;
    end else if (blocked_pre) begin
      decision = lfrg_pkg::DEC_RATE_LIMITED;
    end else if (!is_authenticated) begin
      ctl.record   = active && credential_given;
      ctl.set_cool = active && credential_given && set_cool;
      // A fresh cooldown blocks at once unless the window is zero.
      if (credential_given && set_cool && (window_ms != '0)) begin
        decision = lfrg_pkg::DEC_RATE_LIMITED;
      end else begin
        decision = lfrg_pkg::DEC_CHALLENGE;
      end
    end else begin
      ctl.clear = active;
      if (!is_mutation || mutation_checks_ok) begin
        decision = lfrg_pkg::DEC_ALLOW;
      end else begin
        decision = lfrg_pkg::DEC_FORBIDDEN;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/lfrg_history.sv
// Failure history registers: timestamps, count and cooldown state.
`default_nettype none

module lfrg_history #(
  parameter int FAILURE_SLOTS = lfrg_pkg::FAILURE_SLOTS_DEFAULT,
  localparam int CW = $clog2(FAILURE_SLOTS + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_clear,
  input  wire lfrg_pkg::hist_ctl_t            ctl,
  input  wire logic [31:0]                    now_ms,
  input  wire logic [FAILURE_SLOTS-1:0][31:0] times_next,
  input  wire logic [CW-1:0]                  count_next,
  output logic      [FAILURE_SLOTS-1:0][31:0] times,
  output logic      [CW-1:0]                  count,
  output logic                                cooling,
  output logic      [31:0]                    cooldown_start
);

  // Timestamps hold no reset; only entries below the count are ever used.
  always_ff @(posedge clk) begin
    if (ctl.record) begin
      times <= times_next;
    end
  end

  // Count and cooldown state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      cooling        <= 1'b0;
      cooldown_start <= '0;
    end else if (cfg_clear || ctl.clear) begin
      count   <= '0;
      cooling <= 1'b0;
    end else begin
      if (ctl.record) begin
        count <= count_next;
      end
      if (ctl.set_cool) begin
        cooling        <= 1'b1;
        cooldown_start <= now_ms;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/login_failure_rate_gate_unit.sv
// Top level of the login failure rate gate: config, input and result registers.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_stall | now_ms, is_authenticated, credential_given,
//           |                     | is_mutation, mutation_checks_ok
//   out     | out_valid/out_stall | decision
//   cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request per cycle is accepted while in_stall is low. Its decision is computed from
// the input register and loaded into the result register; timestamp compare, compaction
// and the decision logic sit between those two registers.
// Reset loads the configuration reset values and clears the failure count, the cooldown and both valids.
// A stalled result holds; the input register still fills behind it, and in_stall
// rises only while both registers are full and the result is stalled.
`default_nettype none

module login_failure_rate_gate_unit #(
  parameter int FAILURE_SLOTS = lfrg_pkg::FAILURE_SLOTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Request channel.
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [31:0]                      now_ms,
  input  wire logic                             is_authenticated,
  input  wire logic                             credential_given,
  input  wire logic                             is_mutation,
  input  wire logic                             mutation_checks_ok,
  // Decision channel.
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [2:0]                       decision,
  // Configuration write channel.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lfrg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  localparam int CW = $clog2(FAILURE_SLOTS + 1);

  logic        gate_enabled;
  logic [31:0] window_ms;
  logic [2:0]  failure_limit;
  logic        cfg_write;
  logic        cfg_clear;

  logic        s1_valid;
  logic [31:0] s1_now_ms;
  logic        s1_authenticated;
  logic        s1_credential;
  logic        s1_mutation;
  logic        s1_checks_ok;
  logic        s1_advance;
  logic        in_take;

  logic [FAILURE_SLOTS-1:0][31:0] times;
  logic [FAILURE_SLOTS-1:0][31:0] times_next;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  logic                           cooling;
  logic [31:0]                    cooldown_start;
  lfrg_pkg::hist_ctl_t            ctl;
  logic [2:0]                     decision_next;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_write && (cfg_index == lfrg_pkg::CFG_GATE_ENABLED) && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_enabled  <= 1'b0;
      window_ms     <= lfrg_pkg::WINDOW_MS_RESET;
      failure_limit <= lfrg_pkg::FAILURE_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lfrg_pkg::CFG_GATE_ENABLED:  gate_enabled  <= cfg_data[0];
        lfrg_pkg::CFG_WINDOW_MS:     window_ms     <= cfg_data;
        lfrg_pkg::CFG_FAILURE_LIMIT: failure_limit <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: the input register moves on when the result register is free.
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;
  assign in_take    = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_ms        <= now_ms;
      s1_authenticated <= is_authenticated;
      s1_credential    <= credential_given;
      s1_mutation      <= is_mutation;
      s1_checks_ok     <= mutation_checks_ok;
    end
  end

  lfrg_eval #(
    .FAILURE_SLOTS (FAILURE_SLOTS)
  ) u_eval (
    .active             (s1_advance),
    .gate_enabled       (gate_enabled),
    .window_ms          (window_ms),
    .failure_limit      (failure_limit),
    .now_ms             (s1_now_ms),
    .is_authenticated   (s1_authenticated),
    .credential_given   (s1_credential),
    .is_mutation        (s1_mutation),
    .mutation_checks_ok (s1_checks_ok),
    .times              (times),
    .count              (count),
    .cooling            (cooling),
    .cooldown_start     (cooldown_start),
    .times_next         (times_next),
    .count_next         (count_next),
    .ctl                (ctl),
    .decision           (decision_next)
  );

  lfrg_history #(
    .FAILURE_SLOTS (FAILURE_SLOTS)
  ) u_history (
    .clk            (clk),
    .rst            (rst),
    .cfg_clear      (cfg_clear),
    .ctl            (ctl),
    .now_ms         (s1_now_ms),
    .times_next     (times_next),
    .count_next     (count_next),
    .times          (times),
    .count          (count),
    .cooling        (cooling),
    .cooldown_start (cooldown_start)
  );

  // Result register; holds its value while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      decision <= decision_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lfrg_checker.sv
// Port-level checks on the login failure rate gate, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module lfrg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] decision
);

  // Every decision shown is one of the defined codes.
  `LFRG_ASSERT(a_decision_code, clk, rst, out_valid |-> (decision <= lfrg_pkg::DEC_FORBIDDEN), "decision code out of range")

  // A stalled decision stays on the port unchanged.
  `LFRG_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(decision)), "stalled decision changed")

  // The input side only stalls when the result side is full and stalled.
  `LFRG_ASSERT(a_stall_cause, clk, rst, in_stall |-> (out_valid && out_stall), "input stalled without a stalled result")

  // A request transfer is followed by a valid decision on the port.
  `LFRG_ASSERT(a_latency, clk, rst, (in_valid && !in_stall) |-> ##2 out_valid, "no decision after request")

  // Reset empties the result register.
  `LFRG_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind login_failure_rate_gate_unit lfrg_checker u_lfrg_checker (.*);

`default_nettype wire

### sim/login_failure_rate_gate_unit_test.sv
// Self-checking testbench for the login failure rate gate with randomized traffic and stalls.
`timescale 1ns / 100ps

module login_failure_rate_gate_unit_test;

  localparam int SLOTS = lfrg_pkg::FAILURE_SLOTS_DEFAULT;
  localparam int RANDOM_ITEMS = 1900;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [31:0] now_ms;
  logic is_authenticated;
  logic credential_given;
  logic is_mutation;
  logic mutation_checks_ok;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] decision;
  logic cfg_valid;
  logic cfg_ready;
  logic [lfrg_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  // Mirror of the gate configuration and failure history.
  logic gate_on = 1'b0;
  logic [31:0] window_len = lfrg_pkg::WINDOW_MS_RESET;
  logic [2:0] limit_reg = lfrg_pkg::FAILURE_LIMIT_RESET;
  logic [31:0] hist_times [SLOTS];
  int hist_count = 0;
  logic cool_active = 1'b0;
  logic [31:0] cool_since = '0;

  // Decisions predicted for accepted requests, oldest first.
  logic [2:0] pending_decisions [$];
  int bad_decisions = 0;

  // Idling controls and the running request clock.
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_run = 0;
  logic [31:0] wall_ms = '0;

  login_failure_rate_gate_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .now_ms(now_ms),
    .is_authenticated(is_authenticated),
    .credential_given(credential_given),
    .is_mutation(is_mutation),
    .mutation_checks_ok(mutation_checks_ok),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .decision(decision),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // True when at least one window has passed since the given time, modulo 2^32.
  function automatic logic window_elapsed(input logic [31:0] t, input logic [31:0] since);
    logic [31:0] diff;
    diff = t - since;
    return diff >= window_len;
  endfunction

  // A running cooldown blocks until one window has passed since it started.
  function automatic logic cooldown_blocks(input logic [31:0] t);
    return cool_active && !window_elapsed(t, cool_since);
  endfunction

  // Drop expired failures, append the new one if room is left under the limit,
  // and start a cooldown once the limit is reached.
  function automatic void add_failure(input logic [31:0] t);
    int kept;
    int lim;
    kept = 0;
    lim = (limit_reg == 0) ? 1 : (limit_reg > SLOTS) ? SLOTS : int'(limit_reg);
    for (int i = 0; i < hist_count; i++) begin
      if (!window_elapsed(t, hist_times[i])) begin
        hist_times[kept] = hist_times[i];
        kept++;
      end
    end
    hist_count = kept;
    if (hist_count < lim) begin
      hist_times[hist_count] = t;
      hist_count++;
    end
    if (hist_count >= lim) begin
      cool_active = 1'b1;
      cool_since = t;
    end
  endfunction

  // Decision for one request; updates the mirrored history.
  function automatic logic [2:0] gate_decision(input logic [31:0] t, input logic authd,
                                               input logic cred, input logic mut,
                                               input logic chk);
    if (!gate_on) return lfrg_pkg::DEC_DISABLED;
    if (cooldown_blocks(t)) return lfrg_pkg::DEC_RATE_LIMITED;
    if (!authd) begin
      if (cred) add_failure(t);
      return cooldown_blocks(t) ? lfrg_pkg::DEC_RATE_LIMITED : lfrg_pkg::DEC_CHALLENGE;
    end
    hist_count = 0;
    cool_active = 1'b0;
    return (!mut || chk) ? lfrg_pkg::DEC_ALLOW : lfrg_pkg::DEC_FORBIDDEN;
  endfunction

  function automatic void apply_reg_write(input logic [lfrg_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [31:0] value);
    case (idx)
      lfrg_pkg::CFG_GATE_ENABLED: begin
        gate_on = value[0];
        if (!gate_on) begin
          hist_count = 0;
          cool_active = 1'b0;
        end
      end
      lfrg_pkg::CFG_WINDOW_MS: begin
        window_len = value;
      end
      lfrg_pkg::CFG_FAILURE_LIMIT: begin
        limit_reg = value[2:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Sender idle length: mostly none, sometimes short, rarely long.
  function automatic int next_gap();
    int unsigned pick;
    if (!gaps_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Send one request, holding it until the transfer, then record its prediction.
  task automatic send_request(input logic [31:0] t, input logic authd, input logic cred,
                              input logic mut, input logic chk);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    now_ms <= t;
    is_authenticated <= authd;
    credential_given <= cred;
    is_mutation <= mut;
    mutation_checks_ok <= chk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_decisions.push_back(gate_decision(t, authd, cred, mut, chk));
  endtask

  // Stop sending and wait until every predicted decision has come back.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write, only issued once the gate is idle.
  task automatic set_reg(input logic [lfrg_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [31:0] value);
    drain_pipeline();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver back-pressure: runs of stall and no stall of random length.
  always @(negedge clk) begin
    int unsigned pick;
    if (stall_run > 0) begin
      stall_run--;
    end else if (!stalls_on) begin
      out_stall <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(0, 4);
      end else if (pick < 90) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(5, 30);
      end
    end
  end

  // Compare each decision transfer with the oldest prediction.
  always @(posedge clk) begin
    logic [2:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decisions.size() == 0) begin
        $error("decision: expected none, got %0d", decision);
        bad_decisions++;
      end else begin
        want = pending_decisions.pop_front();
        if (decision !== want) begin
          $error("decision: expected %0d, got %0d", want, decision);
          bad_decisions++;
        end
      end
    end
  end

  // A gate that was never enabled answers disabled for any request.
  task automatic test_disabled_gate();
    send_request(32'd0, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  // Failures up to the reset limit start a cooldown that ends after the window;
  // a success then clears it and mutation checks decide allow or forbidden.
  task automatic test_failure_cooldown();
    set_reg(lfrg_pkg::CFG_GATE_ENABLED, 32'd1);
    send_request(32'd100, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(32'd200, 1'b0, 1'b1, 1'b1, 1'b0);
    send_request(32'd300, 1'b0, 1'b1, 1'b0, 1'b1);
    send_request(32'd400, 1'b0, 1'b1, 1'b1, 1'b1);
    send_request(32'd500, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(32'd1000, 1'b1, 1'b1, 1'b0, 1'b0);
    send_request(32'd60500, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(32'd60600, 1'b1, 1'b1, 1'b1, 1'b0);
    send_request(32'd60700, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  // Zero window never blocks; a cooldown blocks again after the clock wraps round.
  task automatic test_zero_window_and_wrap();
    set_reg(lfrg_pkg::CFG_WINDOW_MS, 32'd0);
    send_request(32'd70000, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(32'd70000, 1'b0, 1'b1, 1'b0, 1'b0);
    set_reg(lfrg_pkg::CFG_WINDOW_MS, 32'd1000);
    set_reg(lfrg_pkg::CFG_FAILURE_LIMIT, 32'd0);
    send_request(32'hFFFF_FF00, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(32'h0000_02E8, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(32'hFFFF_FF10, 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  // Oversized limit, a limit lowered under the stored count, re-enabling,
  // disabling, and the largest window.
  task automatic test_limit_changes();
    set_reg(lfrg_pkg::CFG_FAILURE_LIMIT, 32'd7);
    set_reg(lfrg_pkg::CFG_WINDOW_MS, lfrg_pkg::WINDOW_MS_RESET);
    send_request(32'd100000, 1'b1, 1'b0, 1'b0, 1'b0);
    send_request(32'd100010, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(32'd100020, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(32'd100030, 1'b0, 1'b1, 1'b0, 1'b0);
    set_reg(lfrg_pkg::CFG_FAILURE_LIMIT, 32'd2);
    send_request(32'd100040, 1'b0, 1'b1, 1'b0, 1'b0);
    set_reg(lfrg_pkg::CFG_GATE_ENABLED, 32'd1);
    send_request(32'd100050, 1'b0, 1'b1, 1'b0, 1'b0);
    set_reg(lfrg_pkg::CFG_GATE_ENABLED, 32'd0);
    set_reg(lfrg_pkg::CFG_GATE_ENABLED, 32'd1);
    send_request(32'd100060, 1'b0, 1'b1, 1'b0, 1'b0);
    set_reg(lfrg_pkg::CFG_WINDOW_MS, 32'hFFFF_FFFF);
    send_request(32'd0, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  // Phases of random settings, each driving a stream of mostly failures on a
  // clock that advances in steps scaled to the window.
  task automatic test_random_traffic();
    int sent;
    int phase_len;
    int unsigned pick;
    logic [31:0] win;
    logic [31:0] step;
    logic authd;
    logic cred;
    logic mut;
    logic chk;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // New settings for this phase.
      pick = $urandom_range(0, 9);
      case (pick)
        0: win = 32'd0;
        1: win = 32'd1;
        2: win = 32'hFFFF_FFFF;
        3: win = lfrg_pkg::WINDOW_MS_RESET;
        4, 5, 6, 7: win = $urandom_range(2, 200);
        8: win = $urandom_range(1000, 100000);
        default: win = $urandom;
      endcase
      set_reg(lfrg_pkg::CFG_WINDOW_MS, win);
      set_reg(lfrg_pkg::CFG_FAILURE_LIMIT, $urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        set_reg(lfrg_pkg::CFG_GATE_ENABLED, 32'd0);
      end else if (pick < 30) begin
        set_reg(lfrg_pkg::CFG_GATE_ENABLED, 32'd0);
        set_reg(lfrg_pkg::CFG_GATE_ENABLED, 32'd1);
      end else if (pick < 60 || !gate_on) begin
        set_reg(lfrg_pkg::CFG_GATE_ENABLED, 32'd1);
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) wall_ms = $urandom;

      phase_len = $urandom_range(60, 200);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      repeat (phase_len) begin
        // Advance the request clock.
        pick = $urandom_range(0, 99);
        if (pick < 15) step = 32'd0;
        else if (pick < 60) step = $urandom_range(0, (window_len > 3) ? window_len / 3 : 3);
        else if (pick < 85) step = window_len + $urandom_range(0, 2) - 1;
        else if (pick < 95) step = $urandom_range(0, 50);
        else step = $urandom;
        wall_ms = wall_ms + step;

        // Request kind: mostly credential failures, some successes, some noise.
        mut = 1'($urandom_range(0, 1));
        chk = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          authd = 1'b0;
          cred = 1'b1;
        end else if (pick < 65) begin
          authd = 1'b0;
          cred = 1'b0;
        end else if (pick < 85) begin
          authd = 1'b1;
          cred = 1'b1;
        end else begin
          authd = 1'($urandom_range(0, 1));
          cred = 1'($urandom_range(0, 1));
        end
        send_request(wall_ms, authd, cred, mut, chk);
        sent++;
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    now_ms = '0;
    is_authenticated = 1'b0;
    credential_given = 1'b0;
    is_mutation = 1'b0;
    mutation_checks_ok = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_disabled_gate();
    test_failure_cooldown();
    test_zero_window_and_wrap();
    test_limit_changes();
    test_random_traffic();

    drain_pipeline();
    repeat (10) @(posedge clk);
    if (bad_decisions == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
